// ===== rtl/chte_pkg.sv =====
// chte_pkg: shared constants, operation and status codes, and the
// command/status structs between the controller and the datapath.
// no dependencies
package chte_pkg;

    localparam int NUM_BUCKETS_DEF = 256;
    localparam int CHAIN_WAYS_DEF  = 4;
    localparam int MIN_BUCKETS     = 16;
    localparam int CFG_W           = 9;
    localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 9'd256;

    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = KEY_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int CNT_W     = 5;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_GET = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic       in_ready;
        logic       load;
        logic       div_step;
        logic       clr_step;
        logic       base_load;
        logic       way_clr;
        logic       way_len;
        logic       way_inc;
        logic       rd_next;
        logic       kv_we;
        logic       kv_from_rd;
        logic       len_inc_we;
        logic       len_dec_we;
        logic       res_set;
        logic [1:0] res_status;
        logic       res_found;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic             in_valid;
        logic             out_busy;
        logic             div_done;
        logic             clr_done;
        logic [CNT_W-1:0] len;
        logic [CNT_W-1:0] way;
        logic             hit;
        logic             data_zero;
        logic [1:0]       op;
    } sts_t;

endpackage

// ===== rtl/chte_ifs.sv =====
// chte_in_if / chte_out_if: valid/ready channels for requests and results
// depends on chte_pkg
interface chte_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   operation;
    logic [chte_pkg::KEY_W-1:0]   key;
    logic [chte_pkg::DATA_W-1:0]  entry_data;

    modport source (output valid, output operation, output key, output entry_data,
                    input ready);
    modport sink (input valid, input operation, input key, input entry_data,
                  output ready);
endinterface

interface chte_out_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [chte_pkg::DATA_W-1:0]  found_data;

    modport source (output valid, output status, output found_data, input ready);
    modport sink (input valid, input status, input found_data, output ready);
endinterface

// ===== rtl/chte_dp.sv =====
// chte_dp: datapath with bucket divider, chain memories, length memory,
// result and output registers
// depends on chte_pkg, chte_ifs
module chte_dp #(
    parameter int NUM_BUCKETS = chte_pkg::NUM_BUCKETS_DEF,
    parameter int CHAIN_WAYS  = chte_pkg::CHAIN_WAYS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [chte_pkg::CFG_W-1:0]  cfg_data,
    chte_in_if.sink                     in_ch,
    chte_out_if.source                  out_ch,
    input  chte_pkg::cmd_t              cmd,
    output chte_pkg::sts_t              sts
);
    import chte_pkg::*;

    localparam int NW    = $clog2(NUM_BUCKETS + 1);
    localparam int BKW   = $clog2(NUM_BUCKETS);
    localparam int DEPTH = NUM_BUCKETS * CHAIN_WAYS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(CHAIN_WAYS + 1);

    logic [CFG_W-1:0]  bc_reg;
    logic [BKW-1:0]    clr_reg;
    logic [STEP_W-1:0] step_reg;
    logic              out_valid_reg;

    logic [1:0]        op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] data_reg;
    logic [KEY_W-1:0]  shift_reg;
    logic [NW-1:0]     n_reg;
    logic [NW-1:0]     rem_reg;
    logic [AW-1:0]     base_reg;
    logic [LW-1:0]     way_reg;
    logic [LW-1:0]     len_q;
    logic [KEY_W-1:0]  rd_key_reg;
    logic [DATA_W-1:0] rd_val_reg;
    logic [1:0]        res_status_reg;
    logic [DATA_W-1:0] res_found_reg;
    logic [1:0]        out_status_reg;
    logic [DATA_W-1:0] out_found_reg;

    logic [KEY_W-1:0]  key_mem [DEPTH];
    logic [DATA_W-1:0] val_mem [DEPTH];
    logic [LW-1:0]     len_mem [NUM_BUCKETS];

    logic [NW-1:0]     n_eff;
    logic [NW-1:0]     rem_next;
    logic [BKW-1:0]    bucket;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              len_we;
    logic [BKW-1:0]    len_waddr;
    logic [LW-1:0]     len_wdata;

    always_comb
    begin
        if (bc_reg < CFG_W'(MIN_BUCKETS))
        begin
            n_eff = NW'(MIN_BUCKETS);
        end
        else if (32'(bc_reg) > 32'(NUM_BUCKETS))
        begin
            n_eff = NW'(NUM_BUCKETS);
        end
        else
        begin
            n_eff = NW'(bc_reg);
        end
    end

    // four restoring remainder steps per cycle
    always_comb
    begin
        logic [NW:0]   t;
        logic [NW-1:0] r;
        r = rem_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            t = {r, shift_reg[KEY_W-1-i]};
            if (t >= {1'b0, n_reg})
            begin
                t = t - {1'b0, n_reg};
            end
            r = t[NW-1:0];
        end
        rem_next = r;
    end

    assign bucket    = rem_reg[BKW-1:0];
    assign rd_addr   = base_reg + AW'(way_reg) + AW'(cmd.rd_next);
    assign wr_addr   = base_reg + AW'(way_reg);
    assign len_we    = cmd.clr_step | cmd.len_inc_we | cmd.len_dec_we;
    assign len_waddr = cmd.clr_step ? clr_reg : bucket;

    always_comb
    begin
        priority if (cmd.clr_step)
        begin
            len_wdata = '0;
        end
        else if (cmd.len_inc_we)
        begin
            len_wdata = len_q + LW'(1);
        end
        else
        begin
            len_wdata = len_q - LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg        <= BUCKET_COUNT_RESET;
            clr_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                bc_reg <= cfg_data;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + BKW'(1);
            end
            if (cmd.load)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_ch.operation;
            key_reg   <= in_ch.key;
            data_reg  <= in_ch.entry_data;
            shift_reg <= in_ch.key;
            n_reg     <= n_eff;
            rem_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg   <= rem_next;
            shift_reg <= shift_reg << DIV_BITS;
        end
        if (cmd.base_load)
        begin
            base_reg <= AW'(32'(bucket) * CHAIN_WAYS);
        end
        priority if (cmd.way_clr)
        begin
            way_reg <= '0;
        end
        else if (cmd.way_len)
        begin
            way_reg <= len_q;
        end
        else if (cmd.way_inc)
        begin
            way_reg <= way_reg + LW'(1);
        end
        else
        begin
            way_reg <= way_reg;
        end
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            res_found_reg  <= cmd.res_found ? rd_val_reg : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.kv_we)
        begin
            key_mem[wr_addr] <= cmd.kv_from_rd ? rd_key_reg : key_reg;
            val_mem[wr_addr] <= cmd.kv_from_rd ? rd_val_reg : data_reg;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_val_reg <= val_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        len_q <= len_mem[bucket];
    end

    assign in_ch.ready       = cmd.in_ready;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = out_status_reg;
    assign out_ch.found_data = out_found_reg;

    assign sts.in_valid  = in_ch.valid;
    assign sts.out_busy  = out_valid_reg & ~out_ch.ready;
    assign sts.div_done  = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign sts.clr_done  = (clr_reg == BKW'(NUM_BUCKETS - 1));
    assign sts.len       = CNT_W'(len_q);
    assign sts.way       = CNT_W'(way_reg);
    assign sts.hit       = (rd_key_reg == key_reg);
    assign sts.data_zero = (data_reg == '0);
    assign sts.op        = op_reg;

endmodule

// ===== rtl/chte_ctrl.sv =====
// chte_ctrl: sequencer for clearing, bucket divide, chain scan, shift and result
// depends on chte_pkg
module chte_ctrl #(
    parameter int CHAIN_WAYS = chte_pkg::CHAIN_WAYS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  chte_pkg::sts_t sts,
    output chte_pkg::cmd_t cmd
);
    import chte_pkg::*;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DIV      = 4'd2;
    localparam logic [3:0] S_LEN_RD   = 4'd3;
    localparam logic [3:0] S_DECIDE   = 4'd4;
    localparam logic [3:0] S_ADD_WR   = 4'd5;
    localparam logic [3:0] S_SCAN_RD  = 4'd6;
    localparam logic [3:0] S_SCAN_CMP = 4'd7;
    localparam logic [3:0] S_SH_CHK   = 4'd8;
    localparam logic [3:0] S_SH_RD    = 4'd9;
    localparam logic [3:0] S_SH_WR    = 4'd10;
    localparam logic [3:0] S_FIN      = 4'd11;

    localparam logic [CNT_W-1:0] WAYS = CNT_W'(CHAIN_WAYS);

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_LEN_RD;
                end
            end
            S_LEN_RD:
            begin
                cmd.base_load = 1'b1;
                state_next    = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (sts.op == OP_ADD)
                begin
                    priority if (sts.data_zero)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_INVALID;
                        state_next     = S_FIN;
                    end
                    else if (sts.len >= WAYS)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_FULL;
                        state_next     = S_FIN;
                    end
                    else
                    begin
                        cmd.way_len = 1'b1;
                        state_next  = S_ADD_WR;
                    end
                end
                else
                begin
                    cmd.way_clr = 1'b1;
                    if (sts.len == '0)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_NOT_FOUND;
                        state_next     = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_ADD_WR:
            begin
                cmd.kv_we      = 1'b1;
                cmd.len_inc_we = 1'b1;
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_OK;
                state_next     = S_FIN;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                priority if (sts.hit && sts.op == OP_DEL)
                begin
                    state_next = S_SH_CHK;
                end
                else if (sts.hit)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_found  = 1'b1;
                    state_next     = S_FIN;
                end
                else if (sts.way + CNT_W'(1) == sts.len)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                    state_next     = S_FIN;
                end
                else
                begin
                    cmd.way_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_SH_CHK:
            begin
                if (sts.way + CNT_W'(1) < sts.len)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    cmd.len_dec_we = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = S_FIN;
                end
            end
            S_SH_RD:
            begin
                cmd.rd_next = 1'b1;
                state_next  = S_SH_WR;
            end
            S_SH_WR:
            begin
                cmd.kv_we      = 1'b1;
                cmd.kv_from_rd = 1'b1;
                cmd.way_inc    = 1'b1;
                state_next     = S_SH_CHK;
            end
            S_FIN:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

`ifndef SYNTH
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !cmd.in_ready)
        else $error("request taken during clearing pass");
    a_write_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.kv_we |-> sts.way < WAYS)
        else $error("chain write beyond last way");
    a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.len_dec_we |-> sts.len != '0)
        else $error("delete on empty chain");
    a_result_follows_set: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_set |=> state_reg == S_FIN)
        else $error("result set outside finish path");
`endif

endmodule

// ===== rtl/chained_hash_table_engine.sv =====
// chained_hash_table_engine: top level of the chained hash table
// depends on chte_pkg, chte_ifs, chte_ctrl, chte_dp
//
// requests arrive on in_ch (operation, key, entry_data) and one result per
// request leaves on out_ch (status, found_data); a transfer happens when
// valid and ready are both high. cfg_we writes cfg_data into bucket_count.
// one request is worked at a time: the bucket is key modulo the bucket
// count, clamped to MIN_BUCKETS..NUM_BUCKETS, found by a divider taking 4
// key bits per cycle, then the length memory is read and the chain is
// walked one way at a time through the registered key/data memory port.
// a delete shifts the entries behind the deleted one up by one way.
// after reset the chain length memory is cleared, one bucket per cycle,
// and in_ch.ready stays low meanwhile.
// a result waits in the output register while out_ch.ready is low; a new
// request is still taken and worked, and holds at its end until the
// output register is free.
module chained_hash_table_engine #(
    parameter int NUM_BUCKETS = chte_pkg::NUM_BUCKETS_DEF,
    parameter int CHAIN_WAYS  = chte_pkg::CHAIN_WAYS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [chte_pkg::CFG_W-1:0]  cfg_data,
    chte_in_if.sink                     in_ch,
    chte_out_if.source                  out_ch
);
    import chte_pkg::*;

    cmd_t cmd;
    sts_t sts;

    chte_ctrl #(
        .CHAIN_WAYS(CHAIN_WAYS)
    ) u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .sts  (sts),
        .cmd  (cmd)
    );

    chte_dp #(
        .NUM_BUCKETS(NUM_BUCKETS),
        .CHAIN_WAYS (CHAIN_WAYS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
